// ===== hdl/ipid_pkg.sv =====
// Shared constants and types of the incremental PID unit.
`timescale 1ns / 1ps

package ipid_pkg;

  // Configuration register index width and map
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN       = 3'd0,
    REG_INTEG_GAIN      = 3'd1,
    REG_DERIV_GAIN      = 3'd2,
    REG_STEP_LIMIT_LOW  = 3'd3,
    REG_STEP_LIMIT_HIGH = 3'd4,
    REG_OUT_LIMIT_LOW   = 3'd5,
    REG_OUT_LIMIT_HIGH  = 3'd6,
    REG_START_OUTPUT    = 3'd7
  } cfg_reg_e;

  // Each scaled product term saturates at plus or minus 2^TERM_SAT_LOG
  localparam int unsigned TERM_SAT_LOG = 60;

endpackage

// ===== hdl/ipid_if.sv =====
// Valid/ready channel interfaces of the incremental PID unit.
`timescale 1ns / 1ps

interface ipid_in_if #(
  parameter int unsigned WORD_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] measured;
  logic signed [WORD_WIDTH-1:0] target;
  logic                         enable;

  modport source (output valid, measured, target, enable, input ready);
  modport sink   (input valid, measured, target, enable, output ready);
endinterface

interface ipid_out_if #(
  parameter int unsigned WORD_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

interface ipid_cfg_if #(
  parameter int unsigned WORD_WIDTH = 32
);
  import ipid_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [WORD_WIDTH-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/incremental_pid_with_limits_unit.sv =====
// Incremental (velocity form) PID controller with step and output limits.
`timescale 1ns / 1ps

// One transaction per control period: the error target - measured is saturated
// to the word range, the increment P*(e-e1) + I*e + D*(e-2*e1+e2) is formed
// from three parallel signed multiplies (floor-scaled by FRAC_BITS, each term
// saturated to +-2^60), summed wide, clamped to the step limits and added to
// the accumulator, which is clamped to the output limits and returned as
// drive. With enable low the accumulator becomes zero (then clamped) and the
// stored errors hold. A start_output write loads the accumulator if no item
// advances. An item is registered on acceptance; its result is formed in a
// single combinational pass (three multiplies, a sum and two clamps) and
// registered as drive, a new item taken every cycle while drive is not stalled.
// Configuration is to be written only while idle; the unit does not enforce it.
module incremental_pid_with_limits_unit #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ipid_in_if.sink    in_i,
  ipid_out_if.source out_o,
  ipid_cfg_if.sink   cfg_i
);
  import ipid_pkg::*;

  localparam int unsigned W     = WORD_WIDTH;
  localparam int unsigned DW    = W + 2;            // second difference width
  localparam int unsigned PW    = W + DW;           // full product width
  localparam int unsigned SW    = PW - FRAC_BITS;   // scaled product width
  localparam int unsigned TW    = (SW > TERM_SAT_LOG + 2) ? SW : TERM_SAT_LOG + 2;
  localparam int unsigned SUM_W = TW + 2;

  localparam logic signed [W-1:0]  WMAX = signed'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [W-1:0]  WMIN = signed'({1'b1, {(W-1){1'b0}}});
  localparam logic signed [TW-1:0] TSAT_HI =
    signed'({{(TW-TERM_SAT_LOG-1){1'b0}}, 1'b1, {TERM_SAT_LOG{1'b0}}});
  localparam logic signed [TW-1:0] TSAT_LO = -TSAT_HI;

  // Configuration registers
  logic signed [W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic signed [W-1:0] step_lo_q, step_hi_q, out_lo_q, out_hi_q;

  // Controller state
  logic signed [W-1:0] prev_err_q, older_err_q, accum_q;

  // Input register
  logic                s0_valid_q;
  logic signed [W-1:0] s0_measured_q, s0_target_q;
  logic                s0_enable_q;

  // Result register
  logic                out_valid_q;
  logic signed [W-1:0] drive_q;

  logic advance;
  logic cfg_wr;

  assign advance     = s0_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s0_valid_q || advance;
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.drive = drive_q;

  // Datapath
  logic signed [W:0]       err_raw;
  logic signed [W-1:0]     err;
  logic signed [DW-1:0]    e_x, d1_x, d2_x;
  logic signed [PW-1:0]    prod_p, prod_i, prod_d;
  logic signed [SW-1:0]    sh_p, sh_i, sh_d;
  logic signed [TW-1:0]    tx_p, tx_i, tx_d, t_p, t_i, t_d;
  logic signed [SUM_W-1:0] inc_sum, step_lo_x, step_hi_x;
  logic signed [W-1:0]     inc;
  logic signed [W:0]       acc_raw, out_lo_x, out_hi_x;
  logic signed [W-1:0]     acc_d;

  always_comb begin
    err_raw = (W+1)'(s0_target_q) - (W+1)'(s0_measured_q);
    if (err_raw > (W+1)'(WMAX)) begin
      err = WMAX;
    end else if (err_raw < (W+1)'(WMIN)) begin
      err = WMIN;
    end else begin
      err = err_raw[W-1:0];
    end

    e_x  = DW'(err);
    d1_x = DW'(err) - DW'(prev_err_q);
    d2_x = DW'(err) - (DW'(prev_err_q) <<< 1) + DW'(older_err_q);

    prod_p = PW'(prop_gain_q)  * PW'(d1_x);
    prod_i = PW'(integ_gain_q) * PW'(e_x);
    prod_d = PW'(deriv_gain_q) * PW'(d2_x);

    // Dropping the fraction bits of a signed value rounds toward minus infinity
    sh_p = prod_p[PW-1:FRAC_BITS];
    sh_i = prod_i[PW-1:FRAC_BITS];
    sh_d = prod_d[PW-1:FRAC_BITS];

    tx_p = TW'(sh_p);
    tx_i = TW'(sh_i);
    tx_d = TW'(sh_d);

    t_p = (tx_p > TSAT_HI) ? TSAT_HI : ((tx_p < TSAT_LO) ? TSAT_LO : tx_p);
    t_i = (tx_i > TSAT_HI) ? TSAT_HI : ((tx_i < TSAT_LO) ? TSAT_LO : tx_i);
    t_d = (tx_d > TSAT_HI) ? TSAT_HI : ((tx_d < TSAT_LO) ? TSAT_LO : tx_d);

    inc_sum   = SUM_W'(t_p) + SUM_W'(t_i) + SUM_W'(t_d);
    step_lo_x = SUM_W'(step_lo_q);
    step_hi_x = SUM_W'(step_hi_q);
    // High limit is tested first: with inverted limits a sum above the high one gives it, any other sum the low one
    if (inc_sum > step_hi_x) begin
      inc = step_hi_q;
    end else if (inc_sum < step_lo_x) begin
      inc = step_lo_q;
    end else begin
      inc = inc_sum[W-1:0];
    end

    if (s0_enable_q) begin
      acc_raw = (W+1)'(accum_q) + (W+1)'(inc);
    end else begin
      acc_raw = '0;
    end
    out_lo_x = (W+1)'(out_lo_q);
    out_hi_x = (W+1)'(out_hi_q);
    if (acc_raw > out_hi_x) begin
      acc_d = out_hi_q;
    end else if (acc_raw < out_lo_x) begin
      acc_d = out_lo_q;
    end else begin
      acc_d = acc_raw[W-1:0];
    end
  end

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      deriv_gain_q <= '0;
      step_lo_q    <= WMIN;
      step_hi_q    <= WMAX;
      out_lo_q     <= WMIN;
      out_hi_q     <= WMAX;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_PROP_GAIN:       prop_gain_q  <= signed'(cfg_i.data);
        REG_INTEG_GAIN:      integ_gain_q <= signed'(cfg_i.data);
        REG_DERIV_GAIN:      deriv_gain_q <= signed'(cfg_i.data);
        REG_STEP_LIMIT_LOW:  step_lo_q    <= signed'(cfg_i.data);
        REG_STEP_LIMIT_HIGH: step_hi_q    <= signed'(cfg_i.data);
        REG_OUT_LIMIT_LOW:   out_lo_q     <= signed'(cfg_i.data);
        REG_OUT_LIMIT_HIGH:  out_hi_q     <= signed'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Controller state: advance with each processed item (errors only when enabled), else reload on start write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q  <= '0;
      older_err_q <= '0;
      accum_q     <= '0;
    end else begin
      if (advance) begin
        accum_q <= acc_d;
        if (s0_enable_q) begin
          older_err_q <= prev_err_q;
          prev_err_q  <= err;
        end
      end else if (cfg_wr && cfg_reg_e'(cfg_i.index) == REG_START_OUTPUT) begin
        accum_q <= signed'(cfg_i.data);
      end
    end
  end

  // Input and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s0_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s0_measured_q <= in_i.measured;
      s0_target_q   <= in_i.target;
      s0_enable_q   <= in_i.enable;
    end
    if (advance) begin
      drive_q <= acc_d;
    end
  end

  // Stored errors change only on an enabled, processed transaction
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && s0_enable_q) |=> $stable(prev_err_q) && $stable(older_err_q))
    else $error("stored errors changed without an enabled transaction");

  // The error history shifts by one on each enabled step
  a_err_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s0_enable_q |=> older_err_q == $past(prev_err_q))
    else $error("error history did not shift");

  // A held input item is not dropped while the result side stalls
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q && !advance |=> s0_valid_q)
    else $error("pending transaction lost");

  // A new result appears only after an item was processed
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("result valid without a processed transaction");

endmodule

// ===== sim/incremental_pid_with_limits_unit_test.sv =====
// Self-checking testbench of the incremental PID unit with step and output limits.
`timescale 1ns / 1ps

module incremental_pid_with_limits_unit_test;
  import ipid_pkg::*;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned FRAC_W = 24;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [127:0]      wide_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    word_t measured;
    word_t target;
    logic  enable;
  } pid_sample_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ipid_in_if  #(.WORD_WIDTH(WORD_W)) in_bus ();
  ipid_out_if #(.WORD_WIDTH(WORD_W)) out_bus ();
  ipid_cfg_if #(.WORD_WIDTH(WORD_W)) cfg_bus ();

  incremental_pid_with_limits_unit #(
    .WORD_WIDTH(WORD_W),
    .FRAC_BITS (FRAC_W)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Controller state mirrored by the testbench
  word_t gain_p, gain_i, gain_d;
  word_t step_lo, step_hi, out_lo, out_hi;
  wide_t err_last, err_older, drive_accum;

  pid_sample_t pending_items[$];
  word_t       expected_drive[$];
  word_t       drive_want;

  int unsigned accepted_count = 0;
  int          error_count = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  logic        src_idle_on = 1'b1;
  logic        sink_idle_on = 1'b1;
  logic        hold_off = 1'b0;

  function automatic wide_t limit_to(wide_t v, wide_t lo, wide_t hi);
    // high limit is tested first: with inverted limits, values above hi give hi, all others lo
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic wide_t scaled_term(word_t gain, wide_t diff);
    wide_t sat;
    wide_t prod;
    sat  = wide_t'(1) <<< TERM_SAT_LOG;
    prod = (wide_t'(gain) * diff) >>> FRAC_W;
    return limit_to(prod, -sat, sat);
  endfunction

  function automatic word_t pid_update(pid_sample_t s);
    wide_t err, d1, d2, step, acc;
    if (s.enable) begin
      err  = limit_to(wide_t'(s.target) - wide_t'(s.measured),
                      wide_t'(WORD_MIN), wide_t'(WORD_MAX));
      d1   = err - err_last;
      d2   = err - 2 * err_last + err_older;
      step = scaled_term(gain_p, d1) + scaled_term(gain_i, err) + scaled_term(gain_d, d2);
      step = limit_to(step, wide_t'(step_lo), wide_t'(step_hi));
      acc  = drive_accum + step;
      err_older = err_last;
      err_last  = err;
    end else begin
      acc = '0;
    end
    drive_accum = limit_to(acc, wide_t'(out_lo), wide_t'(out_hi));
    return word_t'(drive_accum[WORD_W-1:0]);
  endfunction

  function automatic void load_register(cfg_reg_e idx, word_t value);
    case (idx)
      REG_PROP_GAIN:       gain_p = value;
      REG_INTEG_GAIN:      gain_i = value;
      REG_DERIV_GAIN:      gain_d = value;
      REG_STEP_LIMIT_LOW:  step_lo = value;
      REG_STEP_LIMIT_HIGH: step_hi = value;
      REG_OUT_LIMIT_LOW:   out_lo = value;
      REG_OUT_LIMIT_HIGH:  out_hi = value;
      REG_START_OUTPUT:    drive_accum = wide_t'(value);
      default: ;
    endcase
  endfunction

  function automatic int pick_gap(logic on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0:          return WORD_MAX;
      1:          return WORD_MIN;
      2:          return '0;
      3, 4, 5, 6: return $urandom;
      default:    return word_t'($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic word_t pick_gain();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0:       return WORD_MAX;
          1:       return WORD_MIN;
          default: return '0;
        endcase
      end
      1, 2:    return $urandom;
      default: return word_t'($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic void pick_limits(output word_t lo, output word_t hi);
    case ($urandom_range(0, 9))
      0: begin
        lo = WORD_MIN;
        hi = WORD_MAX;
      end
      1: begin
        lo = word_t'($urandom_range(0, 32'h0400_0000));
        hi = -word_t'($urandom_range(0, 32'h0400_0000));
      end
      2: begin
        lo = pick_word();
        hi = lo;
      end
      3: begin
        lo = $urandom;
        hi = $urandom;
      end
      default: begin
        lo = -word_t'($urandom_range(0, 32'h0800_0000));
        hi = word_t'($urandom_range(0, 32'h0800_0000));
      end
    endcase
  endfunction

  task automatic add_item(word_t m, word_t t, logic en);
    pending_items.push_back('{measured: m, target: t, enable: en});
  endtask

  task automatic write_register(cfg_reg_e idx, word_t value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    load_register(idx, value);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_bus.valid || expected_drive.size() != 0)
      @(posedge clk_i);
    // let the two-stage pipe settle
    repeat (4) @(posedge clk_i);
  endtask

  // Sender: present the oldest pending sample, hold it until accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_drive.push_back(pid_update(pending_items.pop_front()));
        accepted_count++;
        send_gap = pick_gap(src_idle_on);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_bus.valid    <= 1'b1;
          in_bus.measured <= pending_items[0].measured;
          in_bus.target   <= pending_items[0].target;
          in_bus.enable   <= pending_items[0].enable;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each drive transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_drive.size() == 0) begin
          $display("%0t ns: drive expected none, actual %0d", $time, out_bus.drive);
          error_count++;
        end else begin
          drive_want = expected_drive.pop_front();
          if (out_bus.drive !== drive_want) begin
            $display("%0t ns: drive expected %0d, actual %0d",
                     $time, drive_want, out_bus.drive);
            error_count++;
          end
        end
      end
      if (recv_gap > 0) recv_gap--;
      else recv_gap = pick_gap(sink_idle_on);
      out_bus.ready <= !hold_off && (recv_gap == 0);
    end
  end

  // Long receiver hold-off so the unit fills and back-pressures its input
  initial begin
    while (accepted_count < 60) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (120) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("incremental_pid_with_limits_unit_test: errors");
    $finish;
  end

  initial begin
    word_t lo, hi, m, t;

    rst_ni          = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.measured = '0;
    in_bus.target   = '0;
    in_bus.enable   = 1'b0;
    out_bus.ready   = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = REG_PROP_GAIN;
    cfg_bus.data    = '0;

    gain_p      = '0;
    gain_i      = '0;
    gain_d      = '0;
    step_lo     = WORD_MIN;
    step_hi     = WORD_MAX;
    out_lo      = WORD_MIN;
    out_hi      = WORD_MAX;
    err_last    = '0;
    err_older   = '0;
    drive_accum = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: zero gains keep the output at zero
    add_item(WORD_MAX, WORD_MIN, 1'b1);
    add_item(32'sd1, -32'sd1, 1'b1);
    add_item('0, '0, 1'b0);
    wait_drained();

    // Moderate gains, drive step and output clamps from the error extremes
    write_register(REG_PROP_GAIN, 32'sh0100_0000);
    write_register(REG_INTEG_GAIN, 32'sh0040_0000);
    write_register(REG_DERIV_GAIN, -32'sh0080_0000);
    write_register(REG_STEP_LIMIT_LOW, -32'sh0200_0000);
    write_register(REG_STEP_LIMIT_HIGH, 32'sh0300_0000);
    write_register(REG_OUT_LIMIT_LOW, -32'sh0800_0000);
    write_register(REG_OUT_LIMIT_HIGH, 32'sh0800_0000);
    write_register(REG_START_OUTPUT, 32'sh0010_0000);
    add_item('0, 32'sh0080_0000, 1'b1);
    add_item(32'sh0080_0000, '0, 1'b1);
    add_item(WORD_MIN, WORD_MAX, 1'b1);
    add_item(WORD_MAX, WORD_MIN, 1'b1);
    repeat (4) add_item(WORD_MIN, WORD_MAX, 1'b1);
    add_item(WORD_MIN, WORD_MIN, 1'b0);
    add_item(WORD_MAX, WORD_MAX, 1'b1);
    add_item(-32'sd1, '0, 1'b1);
    add_item('0, -32'sd1, 1'b1);
    wait_drained();

    // Extreme gains, inverted output limits
    write_register(REG_PROP_GAIN, WORD_MAX);
    write_register(REG_INTEG_GAIN, WORD_MIN);
    write_register(REG_DERIV_GAIN, WORD_MAX);
    write_register(REG_STEP_LIMIT_LOW, WORD_MIN);
    write_register(REG_STEP_LIMIT_HIGH, WORD_MAX);
    write_register(REG_OUT_LIMIT_LOW, 32'sh0100_0000);
    write_register(REG_OUT_LIMIT_HIGH, -32'sh0100_0000);
    write_register(REG_START_OUTPUT, WORD_MIN);
    add_item(WORD_MIN, WORD_MAX, 1'b1);
    add_item(WORD_MAX, WORD_MIN, 1'b1);
    add_item('0, '0, 1'b0);
    add_item(32'sd1, '0, 1'b1);
    wait_drained();

    // Inverted step limits, full output range, then ride to the output extremes
    write_register(REG_PROP_GAIN, '0);
    write_register(REG_INTEG_GAIN, WORD_MAX);
    write_register(REG_DERIV_GAIN, WORD_MIN);
    write_register(REG_STEP_LIMIT_LOW, 32'sh0000_0100);
    write_register(REG_STEP_LIMIT_HIGH, -32'sh0000_0100);
    write_register(REG_OUT_LIMIT_LOW, WORD_MIN);
    write_register(REG_OUT_LIMIT_HIGH, WORD_MAX);
    write_register(REG_START_OUTPUT, WORD_MAX);
    add_item(WORD_MIN, WORD_MAX, 1'b1);
    add_item(WORD_MAX, WORD_MIN, 1'b1);
    wait_drained();
    write_register(REG_STEP_LIMIT_LOW, WORD_MIN);
    write_register(REG_STEP_LIMIT_HIGH, WORD_MAX);
    repeat (2) add_item(WORD_MIN, WORD_MAX, 1'b1);
    repeat (2) add_item(WORD_MAX, WORD_MIN, 1'b1);
    wait_drained();

    // Random settings, each followed by a run of mostly enabled periods
    for (int phase = 0; phase < 8; phase++) begin
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) write_register(REG_PROP_GAIN, pick_gain());
      if ($urandom_range(0, 3) != 0) write_register(REG_INTEG_GAIN, pick_gain());
      if ($urandom_range(0, 3) != 0) write_register(REG_DERIV_GAIN, pick_gain());
      if ($urandom_range(0, 3) != 0) begin
        pick_limits(lo, hi);
        write_register(REG_STEP_LIMIT_LOW, lo);
        write_register(REG_STEP_LIMIT_HIGH, hi);
      end
      if ($urandom_range(0, 3) != 0) begin
        pick_limits(lo, hi);
        write_register(REG_OUT_LIMIT_LOW, lo);
        write_register(REG_OUT_LIMIT_HIGH, hi);
      end
      if ($urandom_range(0, 1) != 0) write_register(REG_START_OUTPUT, pick_word());
      repeat (50) begin
        m = pick_word();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5:
            t = m + word_t'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
          default: t = pick_word();
        endcase
        add_item(m, t, $urandom_range(0, 9) != 0);
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("incremental_pid_with_limits_unit_test: clean");
    end else begin
      $display("incremental_pid_with_limits_unit_test: errors");
    end
    $finish;
  end

endmodule
